@@ rtl/bptc_pkg.sv @@
// Package for the barometer pressure/temperature compensation core.
// Holds payload structs, register index codes and datapath constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

  // Raw reading pair
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bptc_in_t;

  // Compensated result
  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [31:0] pressure_pa;
    logic               result_valid;
  } bptc_out_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_C1     = 3'd0,
    REG_C2     = 3'd1,
    REG_C3     = 3'd2,
    REG_C4     = 3'd3,
    REG_C5     = 3'd4,
    REG_C6     = 3'd5,
    REG_LOADED = 3'd6
  } bptc_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_STAGES = 9;

  // Temperature reference and thresholds, expressed on the raw quotient q = TEMP - 2000
  localparam logic signed [19:0] TEMP_REF     = 20'sd2000;
  localparam logic signed [18:0] LOW_OFFSET   = 19'sd3500;
  localparam logic signed [17:0] LOW_LIMIT_Q  = -18'sd3500;
  localparam logic [40:0]        TRUNC_BIAS   = 41'd8388607;

endpackage

`default_nettype wire

@@ rtl/baro_pressure_temp_compensation_core.sv @@
// Top level of the barometer pressure/temperature compensation core.
// Nine-stage pipeline, uses bptc_pkg for payload types and constants.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in       | in_valid / in_ready    | in_data  (raw_pressure, raw_temperature)
//   out      | out_valid / out_ready  | out_data (temperature_centi, pressure_pa,
//            |                        |           result_valid)
//   cfg      | cfg_we                 | cfg_index, cfg_data (16 bit)
//
// One request enters per cycle while in_ready is high; each result passes through stages a to i in order.
// The pipeline depth is set by the chain of multipliers: temperature products, squared
// temperature terms, correction, and the split 24x42 pressure product.
// Synchronous reset clears the coefficients and empties the pipeline.
// A stage holds while the stage after it is full and held, so stalls on the
// output fill bubbles first and never drop or repeat a request.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire bptc_pkg::bptc_in_t     in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output bptc_pkg::bptc_out_t         out_data,
  input  wire                         cfg_we,
  input  wire [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [bptc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bptc_pkg::*;

  // Calibration registers
  logic [15:0] coef_c1, coef_c2, coef_c3, coef_c4, coef_c5, coef_c6;
  logic        calib_loaded;

  // Stage valid bits and advance enables
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  // Stage a
  logic [23:0]        a_d1;
  logic signed [24:0] a_dt;
  logic               a_ld;
  // Stage b
  logic [23:0]        b_d1;
  logic signed [40:0] b_mt, b_mo, b_ms;
  logic [47:0]        b_dd;
  logic               b_ld;
  // Stage c
  logic [23:0]        c_d1;
  logic signed [17:0] c_q;
  logic signed [41:0] c_off, c_sens;
  logic [16:0]        c_t2;
  logic               c_ld;
  // Stage d
  logic [23:0]        d_d1;
  logic signed [19:0] d_temp;
  logic [34:0]        d_tm2;
  logic [35:0]        d_tp2;
  logic               d_lo, d_vlo;
  logic signed [41:0] d_off, d_sens;
  logic [16:0]        d_t2;
  logic               d_ld;
  // Stage e
  logic [23:0]        e_d1;
  logic signed [19:0] e_temp;
  logic [39:0]        e_off2, e_sens2;
  logic               e_lo;
  logic signed [41:0] e_off, e_sens;
  logic [16:0]        e_t2;
  logic               e_ld;
  // Stage f
  logic [23:0]        f_d1;
  logic signed [19:0] f_temp;
  logic signed [41:0] f_off, f_sens;
  logic               f_ld;
  // Stage g
  logic [47:0]        g_plo;
  logic signed [41:0] g_phi;
  logic signed [41:0] g_off;
  logic signed [19:0] g_temp;
  logic               g_ld;
  // Stage h
  logic signed [44:0] h_s;
  logic signed [41:0] h_off;
  logic signed [19:0] h_temp;
  logic               h_ld;

  // Combinational products and terms
  logic signed [24:0] dt_next;
  logic signed [40:0] mt_full, mo_full, ms_full;
  logic signed [49:0] dd_full;
  logic [40:0]        mt_biased;
  logic signed [35:0] tm2_full;
  logic signed [18:0] tp;
  logic signed [37:0] tp2_full;
  logic [37:0]        f5;
  logic [38:0]        t8, t7, t11;
  logic signed [41:0] phi_full;
  logic [47:0]        plo_full;
  logic signed [47:0] x_full;

  // Chain enables back from the output register
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NUM_STAGES-1];

  // Write calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_c1      <= '0;
      coef_c2      <= '0;
      coef_c3      <= '0;
      coef_c4      <= '0;
      coef_c5      <= '0;
      coef_c6      <= '0;
      calib_loaded <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_C1:     coef_c1      <= cfg_data;
        REG_C2:     coef_c2      <= cfg_data;
        REG_C3:     coef_c3      <= cfg_data;
        REG_C4:     coef_c4      <= cfg_data;
        REG_C5:     coef_c5      <= cfg_data;
        REG_C6:     coef_c6      <= cfg_data;
        REG_LOADED: calib_loaded <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Datapath arithmetic
  always_comb begin
    dt_next   = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, coef_c5, 8'h00});
    mt_full   = a_dt * $signed({1'b0, coef_c6});
    mo_full   = a_dt * $signed({1'b0, coef_c4});
    ms_full   = a_dt * $signed({1'b0, coef_c3});
    dd_full   = a_dt * a_dt;
    // Bias negative quotients so the shift truncates toward zero
    mt_biased = b_mt[40] ? (b_mt + TRUNC_BIAS) : b_mt;
    tm2_full  = c_q * c_q;
    tp        = {c_q[17], c_q} + LOW_OFFSET;
    tp2_full  = tp * tp;
    f5        = {1'b0, d_tm2, 2'b00} + {3'b000, d_tm2};
    t8        = {d_tp2, 3'b000};
    t7        = t8 - {3'b000, d_tp2};
    t11       = t8 + {2'b00, d_tp2, 1'b0} + {3'b000, d_tp2};
    phi_full  = $signed({1'b0, f_d1}) * $signed(f_sens[41:24]);
    plo_full  = f_d1 * f_sens[23:0];
    x_full    = {{3{h_s[44]}}, h_s} - {{6{h_off[41]}}, h_off};
  end

  // Stage a: capture reading, form temperature difference
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_d1 <= in_data.raw_pressure;
      a_dt <= dt_next;
      a_ld <= calib_loaded;
    end
  end

  // Stage b: temperature, offset, sensitivity and squared products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_d1 <= a_d1;
      b_mt <= mt_full;
      b_mo <= mo_full;
      b_ms <= ms_full;
      b_dd <= dd_full[47:0];
      b_ld <= a_ld;
    end
  end

  // Stage c: first-order temperature, offset and sensitivity
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_d1   <= b_d1;
      c_q    <= $signed(mt_biased[40:23]);
      c_off  <= $signed({10'b0, coef_c2, 16'b0}) + $signed({{8{b_mo[40]}}, b_mo[40:7]});
      c_sens <= $signed({11'b0, coef_c1, 15'b0}) + $signed({{9{b_ms[40]}}, b_ms[40:8]});
      c_t2   <= b_dd[47:31];
      c_ld   <= b_ld;
    end
  end

  // Stage d: square the temperature deviations, flag the cold ranges
  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_d1   <= c_d1;
      d_temp <= {{2{c_q[17]}}, c_q} + TEMP_REF;
      d_tm2  <= tm2_full[34:0];
      d_tp2  <= tp2_full[35:0];
      d_lo   <= c_q[17];
      d_vlo  <= c_q < LOW_LIMIT_Q;
      d_off  <= c_off;
      d_sens <= c_sens;
      d_t2   <= c_t2;
      d_ld   <= c_ld;
    end
  end

  // Stage e: second-order offset and sensitivity terms
  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_d1    <= d_d1;
      e_temp  <= d_temp;
      e_off2  <= {3'b000, f5[37:1]} + (d_vlo ? {1'b0, t7} : 40'd0);
      e_sens2 <= {4'b0000, f5[37:2]} + (d_vlo ? {2'b00, t11[38:1]} : 40'd0);
      e_lo    <= d_lo;
      e_off   <= d_off;
      e_sens  <= d_sens;
      e_t2    <= d_t2;
      e_ld    <= d_ld;
    end
  end

  // Stage f: apply the correction below 20.00 C
  always_ff @(posedge clk) begin
    if (en[5]) begin
      f_d1 <= e_d1;
      f_ld <= e_ld;
      if (e_lo) begin
        f_temp <= e_temp - $signed({3'b000, e_t2});
        f_off  <= e_off - $signed({2'b00, e_off2});
        f_sens <= e_sens - $signed({2'b00, e_sens2});
      end else begin
        f_temp <= e_temp;
        f_off  <= e_off;
        f_sens <= e_sens;
      end
    end
  end

  // Stage g: split pressure product into two partial products
  always_ff @(posedge clk) begin
    if (en[6]) begin
      g_plo  <= plo_full;
      g_phi  <= phi_full;
      g_off  <= f_off;
      g_temp <= f_temp;
      g_ld   <= f_ld;
    end
  end

  // Stage h: combine partials, keep the product scaled down by 2^21
  always_ff @(posedge clk) begin
    if (en[7]) begin
      h_s    <= $signed({g_phi, 3'b000}) + $signed({18'b0, g_plo[47:21]});
      h_off  <= g_off;
      h_temp <= g_temp;
      h_ld   <= g_ld;
    end
  end

  // Stage i: subtract offset, scale by 2^15, zero when uncalibrated
  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_data.result_valid      <= h_ld;
      out_data.temperature_centi <= h_ld ? h_temp[18:0] : 19'sd0;
      out_data.pressure_pa       <= h_ld ? x_full[46:15] : 32'sd0;
    end
  end

endmodule

`default_nettype wire
